// ----- hw/rtl/cks_table_pkg.sv -----
package cks_table_pkg;

  typedef enum logic [1:0] {
    StFound   = 2'd0,
    StCreated = 2'd1,
    StFull    = 2'd2,
    StCleared = 2'd3
  } status_e;

  localparam logic ModeLookup = 1'b0;
  localparam logic ModeClear  = 1'b1;

  localparam int unsigned FieldBits = 16;
  localparam int unsigned IndexBits = 4;

endpackage

// ----- hw/rtl/coordinate_keyed_slot_table.sv -----
// One comparator walks the slot key memory one slot per cycle, so a lookup
// scans at most every slot and ends early on a hit; a clear skips the scan.
// A finished result waits in the output register; the next item is taken only
// when the block is back in idle. Reset clears all used flags, the state and
// the valid flags; stored keys and the other registers are not reset.
module coordinate_keyed_slot_table #(
  parameter int unsigned SLOT_COUNT = 16,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  mode_i,
  input  logic signed [cks_table_pkg::FieldBits-1:0] key_x_i,
  input  logic signed [cks_table_pkg::FieldBits-1:0] key_y_i,
  input  logic signed [cks_table_pkg::FieldBits-1:0] key_z_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [cks_table_pkg::IndexBits-1:0]   slot_index_o,
  output logic [1:0]                            status_o
);

  localparam int unsigned KeyW =
    (COORD_BITS < cks_table_pkg::FieldBits) ? COORD_BITS : cks_table_pkg::FieldBits;
  localparam int unsigned WordW = 3 * KeyW;
  localparam int unsigned IdxW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOT_COUNT - 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0] state_q, state_d;

  logic [SLOT_COUNT-1:0] used_q;
  logic [WordW-1:0]      key_mem [SLOT_COUNT];

  logic [WordW-1:0] key_q;
  logic [IdxW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [WordW-1:0] rd_word_q;
  logic             rd_used_q;
  logic [IdxW-1:0]  cmp_idx_q;
  logic             cmp_vld_q;
  logic             free_vld_q, free_vld_d;
  logic [IdxW-1:0]  free_idx_q, free_idx_d;

  cks_table_pkg::status_e res_status_q, res_status_d;
  logic [IdxW-1:0]        res_idx_q, res_idx_d;

  logic                                out_valid_q;
  logic [cks_table_pkg::IndexBits-1:0] slot_index_q;
  logic [1:0]                          status_q;

  logic in_acc;
  logic out_load;
  logic hit;

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == StDone) && (!out_valid_q || out_ready_i);
  assign hit        = rd_used_q && (rd_word_q == key_q);

  always_comb begin
    state_d      = state_q;
    rd_ptr_d     = rd_ptr_q;
    free_vld_d   = free_vld_q;
    free_idx_d   = free_idx_q;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          rd_ptr_d   = '0;
          free_vld_d = 1'b0;
          res_idx_d  = '0;
          if (mode_i == cks_table_pkg::ModeClear) begin
            res_status_d = cks_table_pkg::StCleared;
            state_d      = StDone;
          end else begin
            state_d = StScan;
          end
        end
      end
      StScan: begin
        if (rd_ptr_q != LastIdx) begin
          rd_ptr_d = rd_ptr_q + 1'b1;
        end
        if (cmp_vld_q) begin
          if (hit) begin
            res_status_d = cks_table_pkg::StFound;
            res_idx_d    = cmp_idx_q;
            state_d      = StDone;
          end else begin
            // note the lowest free slot
            if (!rd_used_q && !free_vld_q) begin
              free_vld_d = 1'b1;
              free_idx_d = cmp_idx_q;
            end
            if (cmp_idx_q == LastIdx) begin
              state_d = StDone;
              if (free_vld_d) begin
                res_status_d = cks_table_pkg::StCreated;
                res_idx_d    = free_idx_d;
              end else begin
                res_status_d = cks_table_pkg::StFull;
                res_idx_d    = '0;
              end
            end
          end
        end
      end
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      used_q      <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= (state_q == StScan);
      if (out_load) begin
        out_valid_q <= 1'b1;
        if (res_status_q == cks_table_pkg::StCleared) begin
          used_q <= '0;
        end else if (res_status_q == cks_table_pkg::StCreated) begin
          used_q[res_idx_q] <= 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q     <= rd_ptr_d;
    free_vld_q   <= free_vld_d;
    free_idx_q   <= free_idx_d;
    res_status_q <= res_status_d;
    res_idx_q    <= res_idx_d;
    rd_used_q    <= used_q[rd_ptr_q];
    cmp_idx_q    <= rd_ptr_q;
    if (in_acc) begin
      key_q <= {key_x_i[KeyW-1:0], key_y_i[KeyW-1:0], key_z_i[KeyW-1:0]};
    end
    if (out_load) begin
      slot_index_q <= cks_table_pkg::IndexBits'(res_idx_q);
      status_q     <= res_status_q;
    end
  end

  // key memory: one read port for the scan, one write port for the commit
  always_ff @(posedge clk_i) begin
    rd_word_q <= key_mem[rd_ptr_q];
    if (out_load && (res_status_q == cks_table_pkg::StCreated)) begin
      key_mem[res_idx_q] <= key_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign slot_index_o = slot_index_q;
  assign status_o     = status_q;

  a_found_is_used : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (res_status_q == cks_table_pkg::StFound)) |-> used_q[res_idx_q])
    else $error("found result points at an unused slot");

  a_create_sets_used : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (res_status_q == cks_table_pkg::StCreated)) |=>
      used_q[$past(res_idx_q)])
    else $error("created slot not marked used");

  a_clear_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (res_status_q == cks_table_pkg::StCleared)) |=> (used_q == '0))
    else $error("clear left a slot marked used");

  a_full_means_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (res_status_q == cks_table_pkg::StFull)) |-> (&used_q))
    else $error("full reported while a slot is free");

endmodule
